// ===== src/tts_pkg.sv =====
// shared types and codes for the tick task scheduler table
package tts_pkg;

  // request codes carried in req_type
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // one request transaction
  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  task_id;
    logic [15:0] start_delay;
    logic [15:0] period;
  } req_t;

  // one result transaction
  typedef struct packed {
    logic       fired;
    logic [7:0] fired_id;
    logic       ok;
    logic       last;
  } res_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_REJECT,
    ST_SCAN
  } ctrl_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic add;
    logic reject;
    logic scan;
    logic finish;
  } ctl_cmd_t;

endpackage

// ===== src/tts_ram.sv =====
// generic single write port ram with registered read
module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tts_ctrl.sv =====
// controller state machine for the tick task scheduler table
module tts_ctrl import tts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] req_type_i,
  input  logic       scan_done_i,
  output logic       busy_o,
  output ctl_cmd_t   cmd_o
);

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          unique case (req_type_i) inside
            REQ_ADD:                state_d = ST_ADD;
            REQ_REMOVE, REQ_TICK:   state_d = ST_SCAN;
            default:                state_d = ST_REJECT;
          endcase
        end
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_REJECT: begin
        cmd_o.reject = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (scan_done_i) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== src/tts_dpath.sv =====
// datapath: task table, streaming compaction walk and result register
module tts_dpath import tts_pkg::*; #(
  parameter int MAX_TASKS = 16,
  parameter int ID_BITS   = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  req_t     req_i,
  input  ctl_cmd_t cmd_i,
  output logic     scan_done_o,
  output logic     done_o,
  output res_t     res_o
);

  localparam int AW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int ENT_W = ID_BITS + 32;

  // latched request
  req_t             req_q;
  logic [ID_BITS-1:0] req_id;

  // table fill level and walk pointers
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] wr_q, wr_d;
  logic             rd_pend_q, rd_pend_d;
  logic             found_q, found_d;

  // held firing, sent once the next one or the end of the walk is known
  logic               pend_q, pend_d;
  logic [ID_BITS-1:0] pend_id_q, pend_id_d;

  // result register
  logic done_q, done_d;
  res_t res_q, res_d;

  // ram ports
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [ENT_W-1:0] wdata, rdata;
  logic [ID_BITS-1:0] e_id;
  logic [15:0]        e_dly, e_per;

  assign req_id = ID_BITS'(req_q.task_id);
  assign e_id   = rdata[ENT_W-1 -: ID_BITS];
  assign e_dly  = rdata[31:16];
  assign e_per  = rdata[15:0];

  tts_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  // control and status registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rd_q      <= '0;
      wr_q      <= '0;
      rd_pend_q <= 1'b0;
      found_q   <= 1'b0;
      pend_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      count_q   <= count_d;
      rd_q      <= rd_d;
      wr_q      <= wr_d;
      rd_pend_q <= rd_pend_d;
      found_q   <= found_d;
      pend_q    <= pend_d;
      done_q    <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_id_q <= pend_id_d;
    res_q     <= res_d;
  end

  assign scan_done_o = (rd_q >= count_q) && !rd_pend_q;

  // walk: read one entry a cycle, write survivors back packed toward the front
  always_comb begin
    count_d   = count_q;
    rd_d      = rd_q;
    wr_d      = wr_q;
    rd_pend_d = 1'b0;
    found_d   = found_q;
    pend_d    = pend_q;
    pend_id_d = pend_id_q;
    done_d    = 1'b0;
    res_d     = res_q;
    we        = 1'b0;
    waddr     = wr_q[AW-1:0];
    wdata     = rdata;
    raddr     = rd_q[AW-1:0];

    if (cmd_i.load) begin
      rd_d    = '0;
      wr_d    = '0;
      found_d = 1'b0;
      pend_d  = 1'b0;
    end

    // append a task when there is room, else report failure
    if (cmd_i.add) begin
      waddr = count_q[AW-1:0];
      wdata = {req_id, req_q.start_delay, req_q.period};
      if (count_q < CNT_W'(MAX_TASKS)) begin
        we      = 1'b1;
        count_d = count_q + 1'b1;
        res_d   = '{fired: 1'b0, fired_id: 8'd0, ok: 1'b1, last: 1'b1};
      end else begin
        res_d   = '{fired: 1'b0, fired_id: 8'd0, ok: 1'b0, last: 1'b1};
      end
      done_d = 1'b1;
    end

    // unknown request code
    if (cmd_i.reject) begin
      res_d  = '{fired: 1'b0, fired_id: 8'd0, ok: 1'b0, last: 1'b1};
      done_d = 1'b1;
    end

    if (cmd_i.scan) begin
      // issue the next read
      if (rd_q < count_q) begin
        rd_d      = rd_q + 1'b1;
        rd_pend_d = 1'b1;
      end

      // handle the entry read last cycle
      if (rd_pend_q) begin
        if (req_q.req_type == REQ_TICK) begin
          if (e_dly != 16'd0) begin
            we    = 1'b1;
            wdata = {e_id, e_dly - 16'd1, e_per};
            wr_d  = wr_q + 1'b1;
          end else begin
            if (pend_q) begin
              res_d  = '{fired: 1'b1, fired_id: 8'(pend_id_q), ok: 1'b1, last: 1'b0};
              done_d = 1'b1;
            end
            pend_d    = 1'b1;
            pend_id_d = e_id;
            if (e_per != 16'd0) begin
              we    = 1'b1;
              wdata = {e_id, e_per - 16'd1, e_per};
              wr_d  = wr_q + 1'b1;
            end
          end
        end else begin
          // remove: drop only the first matching entry
          if (!found_q && (e_id == req_id)) begin
            found_d = 1'b1;
          end else begin
            we   = 1'b1;
            wr_d = wr_q + 1'b1;
          end
        end
      end

      // end of walk
      if (cmd_i.finish) begin
        count_d = wr_q;
        if (req_q.req_type == REQ_TICK) begin
          if (pend_q) begin
            res_d  = '{fired: 1'b1, fired_id: 8'(pend_id_q), ok: 1'b1, last: 1'b1};
            done_d = 1'b1;
          end
          pend_d = 1'b0;
        end else begin
          res_d  = '{fired: 1'b0, fired_id: 8'd0, ok: found_q, last: 1'b1};
          done_d = 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== src/tick_task_scheduler_table.sv =====
// top level of the tick task scheduler table
//
// Holds an ordered table of up to MAX_TASKS tasks (id, remaining delay, period).
// A request transaction is taken at a rising edge with start_i high and busy_o
// low; req_i carries the request code, task id, start delay and period.
// Results leave on res_o, each marked by done_o for exactly one cycle; the
// receiver must take every result, it cannot hold them off.
// Add and unknown requests each give one result from the add or reject state.
// Remove and tick walk the live entries through the table ram, one entry per
// cycle, writing survivors back compacted; busy_o stays high until the walk
// ends. A tick gives one result per firing task (the last one flagged) and
// none if no task is due; remove gives one result at the end of the walk.
// The single read port of the table ram sets the walk rate.
// Reset empties the table at once; ram contents are not cleared.
module tick_task_scheduler_table import tts_pkg::*; #(
  parameter int MAX_TASKS = 16,
  parameter int ID_BITS   = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output res_t res_o
);

  ctl_cmd_t cmd;
  logic     scan_done;

  // sequencing
  tts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_type_i  (req_i.req_type),
    .scan_done_i (scan_done),
    .busy_o      (busy_o),
    .cmd_o       (cmd)
  );

  // table and result path
  tts_dpath #(
    .MAX_TASKS (MAX_TASKS),
    .ID_BITS   (ID_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .scan_done_o (scan_done),
    .done_o      (done_o),
    .res_o       (res_o)
  );

endmodule

// ===== test/tts_checker.sv =====
// checker for the tick task scheduler table: predicts results and compares them
`timescale 1ns / 100ps

module tts_checker import tts_pkg::*; #(
  parameter int MAX_TASKS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  input  logic busy_i,
  input  logic done_i,
  input  res_t res_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);

  // shadow copy of the task table
  logic [7:0]  shadow_id    [MAX_TASKS];
  logic [15:0] shadow_delay [MAX_TASKS];
  logic [15:0] shadow_period[MAX_TASKS];
  int          shadow_live;

  res_t expected_results[$];
  int   mismatch_count;
  int   checked_count;

  // close the gap left by a removed entry
  task automatic drop_shadow_entry(input int pos);
    int j;
    for (j = pos; j + 1 < shadow_live; j++) begin
      shadow_id[j]     = shadow_id[j + 1];
      shadow_delay[j]  = shadow_delay[j + 1];
      shadow_period[j] = shadow_period[j + 1];
    end
    shadow_live--;
  endtask

  // apply one accepted request to the shadow table and queue its results
  task automatic schedule_request(input req_t r);
    int         k;
    bit         found;
    logic [7:0] fired_ids[$];
    res_t       rr;
    rr      = '0;
    rr.last = 1'b1;
    case (r.req_type)
      REQ_ADD: begin
        if (shadow_live < MAX_TASKS) begin
          shadow_id[shadow_live]     = r.task_id;
          shadow_delay[shadow_live]  = r.start_delay;
          shadow_period[shadow_live] = r.period;
          shadow_live++;
          rr.ok = 1'b1;
        end
        expected_results.push_back(rr);
      end
      REQ_REMOVE: begin
        found = 1'b0;
        for (k = 0; k < shadow_live && !found; k++) begin
          if (shadow_id[k] == r.task_id) begin
            drop_shadow_entry(k);
            found = 1'b1;
          end
        end
        rr.ok = found;
        expected_results.push_back(rr);
      end
      REQ_TICK: begin
        // walk in table order; a removed one-shot lets the next entry slide in
        k = 0;
        while (k < shadow_live) begin
          if (shadow_delay[k] != 16'd0) begin
            shadow_delay[k] = shadow_delay[k] - 16'd1;
            k++;
          end else begin
            fired_ids.push_back(shadow_id[k]);
            if (shadow_period[k] == 16'd0) begin
              drop_shadow_entry(k);
            end else begin
              shadow_delay[k] = shadow_period[k] - 16'd1;
              k++;
            end
          end
        end
        foreach (fired_ids[i]) begin
          rr.fired    = 1'b1;
          rr.fired_id = fired_ids[i];
          rr.ok       = 1'b1;
          rr.last     = (i == fired_ids.size() - 1);
          expected_results.push_back(rr);
        end
      end
      default: begin
        expected_results.push_back(rr);
      end
    endcase
  endtask

  // compare a result transaction with the oldest expectation
  task automatic check_result(input res_t act);
    res_t exp_res;
    if (expected_results.size() == 0) begin
      if (mismatch_count < 10)
        $display("%0t: unexpected result fired=%0b id=%0d ok=%0b last=%0b",
                 $realtime, act.fired, act.fired_id, act.ok, act.last);
      mismatch_count++;
    end else begin
      exp_res = expected_results.pop_front();
      checked_count++;
      if (exp_res.fired !== act.fired || exp_res.fired_id !== act.fired_id ||
          exp_res.ok !== act.ok || exp_res.last !== act.last) begin
        if (mismatch_count < 10)
          $display("%0t: result mismatch exp fired=%0b id=%0d ok=%0b last=%0b, got fired=%0b id=%0d ok=%0b last=%0b",
                   $realtime, exp_res.fired, exp_res.fired_id, exp_res.ok, exp_res.last,
                   act.fired, act.fired_id, act.ok, act.last);
        mismatch_count++;
      end
    end
  endtask

  // results first, then new requests: no request yields a result at its own edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_live    = 0;
      mismatch_count = 0;
      checked_count  = 0;
      expected_results.delete();
    end else begin
      if (done_i)
        check_result(res_i);
      if (start_i && !busy_i)
        schedule_request(req_i);
    end
    fail_count_o <= mismatch_count;
    pending_o    <= expected_results.size();
    checked_o    <= checked_count;
  end

endmodule

// ===== test/testbench.sv =====
// top of the tick task scheduler table testbench: stimulus and verdict
`timescale 1ns / 100ps

module testbench;
  import tts_pkg::*;

  localparam int         TABLE_DEPTH    = 16;
  localparam logic [1:0] REQ_UNKNOWN    = 2'd3;
  localparam int         ITEMS_PER_PASS = 100;
  localparam int         DRAIN_LIMIT    = 4000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic done_o;
  res_t res_o;

  int fail_count;
  int pending_results;
  int checked_results;

  int add_count;
  int remove_count;
  int tick_count;
  int unknown_count;

  initial begin
    start_i = 1'b0;
    req_i   = '0;
  end

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tick_task_scheduler_table #(
    .MAX_TASKS(TABLE_DEPTH),
    .ID_BITS  (8)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  tts_checker #(
    .MAX_TASKS(TABLE_DEPTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_i      (busy_o),
    .done_i      (done_o),
    .res_i       (res_o),
    .fail_count_o(fail_count),
    .pending_o   (pending_results),
    .checked_o   (checked_results)
  );

  // mostly a small pool of ids so that removes tend to hit live tasks
  function automatic logic [7:0] pick_task_id();
    if ($urandom_range(9) == 0)
      return 8'($urandom);
    return 8'($urandom_range(15));
  endfunction

  // random request with well-formed content most of the time
  function automatic req_t random_request();
    req_t        r;
    int unsigned roll;
    r.req_type    = REQ_TICK;
    r.task_id     = 8'($urandom);
    r.start_delay = 16'($urandom);
    r.period      = 16'($urandom);
    roll          = $urandom_range(99);
    if (roll < 30) begin
      r.req_type = REQ_ADD;
      r.task_id  = pick_task_id();
      if ($urandom_range(15) != 0)
        r.start_delay = 16'($urandom_range(6));
      roll = $urandom_range(99);
      if (roll < 30)
        r.period = '0;
      else if (roll < 85)
        r.period = 16'($urandom_range(6, 1));
    end else if (roll < 50) begin
      r.req_type = REQ_REMOVE;
      r.task_id  = pick_task_id();
    end else if (roll >= 95) begin
      r.req_type = REQ_UNKNOWN;
    end
    return r;
  endfunction

  // sender gaps with random junk on the bus while start is low
  task automatic sender_gaps(input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      req_i   <= req_t'({$urandom, $urandom});
    end
  endtask

  // present one request and hold it until the block takes it
  task automatic issue_request(input req_t r, input int idle_pct);
    sender_gaps(idle_pct);
    @(negedge clk_i);
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o)
      @(posedge clk_i);
    case (r.req_type)
      REQ_ADD:    add_count++;
      REQ_REMOVE: remove_count++;
      REQ_TICK:   tick_count++;
      default:    unknown_count++;
    endcase
  endtask

  task automatic issue_fields(input logic [1:0] kind, input logic [7:0] id,
                              input logic [15:0] dly, input logic [15:0] per);
    req_t r;
    r.req_type    = kind;
    r.task_id     = id;
    r.start_delay = dly;
    r.period      = per;
    issue_request(r, 7);
  endtask

  // hold off until every expected result has come, within a bound
  task automatic wait_results_drained();
    int cycles;
    cycles = 0;
    @(negedge clk_i);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0 && cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
  endtask

  // main sequence
  initial begin
    int idle_pct[3];
    idle_pct[0] = 7;
    idle_pct[1] = 85;
    idle_pct[2] = 0;
    add_count     = 0;
    remove_count  = 0;
    tick_count    = 0;
    unknown_count = 0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table: quiet tick, remove with nothing live, unknown request
    issue_fields(REQ_TICK,    8'h3C, 16'hFFFF, 16'hFFFF);
    issue_fields(REQ_REMOVE,  8'd7,  16'h0000, 16'h0000);
    issue_fields(REQ_UNKNOWN, 8'hFF, 16'hFFFF, 16'hFFFF);

    // fill the table: adjacent due one-shots, duplicates, field extremes
    issue_fields(REQ_ADD, 8'd1,   16'd0,     16'd0);
    issue_fields(REQ_ADD, 8'd2,   16'd0,     16'd0);
    issue_fields(REQ_ADD, 8'd0,   16'd0,     16'd1);
    issue_fields(REQ_ADD, 8'd255, 16'hFFFF,  16'hFFFF);
    issue_fields(REQ_ADD, 8'd3,   16'd1,     16'd2);
    issue_fields(REQ_ADD, 8'd3,   16'd0,     16'd0);
    issue_fields(REQ_ADD, 8'd4,   16'd2,     16'd0);
    issue_fields(REQ_ADD, 8'd5,   16'd0,     16'd3);
    issue_fields(REQ_ADD, 8'd6,   16'h5555,  16'hAAAA);
    issue_fields(REQ_ADD, 8'd7,   16'd0,     16'd0);
    issue_fields(REQ_ADD, 8'd8,   16'd1,     16'd1);
    issue_fields(REQ_ADD, 8'd9,   16'd0,     16'd0);
    issue_fields(REQ_ADD, 8'd10,  16'd3,     16'd4);
    issue_fields(REQ_ADD, 8'd11,  16'd0,     16'd2);
    issue_fields(REQ_ADD, 8'd12,  16'hAAAA,  16'h5555);
    issue_fields(REQ_ADD, 8'd13,  16'd0,     16'd0);
    // table full: rejected
    issue_fields(REQ_ADD, 8'd14,  16'd0,     16'd0);

    // ticks with several firings and removals mid walk
    issue_fields(REQ_TICK, 8'h00, 16'h0000, 16'h0000);
    issue_fields(REQ_TICK, 8'hA5, 16'hFFFF, 16'hFFFF);

    // absent id, the periodic id 3 left after its one-shot duplicate fired, the extreme id
    issue_fields(REQ_REMOVE, 8'd200, 16'h0000, 16'h0000);
    issue_fields(REQ_REMOVE, 8'd3,   16'h0000, 16'h0000);
    issue_fields(REQ_REMOVE, 8'd255, 16'hFFFF, 16'hFFFF);

    // random traffic in three sender idling passes, draining after each
    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < ITEMS_PER_PASS; i++)
        issue_request(random_request(), idle_pct[p]);
      wait_results_drained();
    end

    // let any stray late result show up
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);

    $display("requests: %0d add, %0d remove, %0d tick, %0d unknown; %0d results checked",
             add_count, remove_count, tick_count, unknown_count, checked_results);
    if (pending_results != 0)
      $display("%0d expected results never arrived", pending_results);
    if (fail_count == 0 && pending_results == 0) begin
      $display("tick_task_scheduler_table verification clean");
    end else begin
      $display("tick_task_scheduler_table verification failed");
    end
    $finish;
  end

  // run time limit
  initial begin
    #2000000;
    $display("timeout waiting on the block");
    $display("tick_task_scheduler_table verification failed");
    $finish;
  end

endmodule
